FILE: hdl/lvf_pkg.sv
// ============================================================================
// lvf_pkg
// Shared types and constants for the local variance edge preserving filter:
// register map, field widths, controller commands and datapath status.
// ============================================================================
package lvf_pkg;

    localparam int PIX_W = 8;
    localparam int NCH   = 3;
    localparam int WS_W  = 4;
    localparam int NL_W  = 16;
    localparam int PLW_W = 11;
    localparam int ROW_W = 11;
    localparam int VAR_W = 22;   // variance in Q.8 never exceeds 255*255/4 * 256
    localparam int K_W   = 16;
    localparam int DEN_W = 25;   // var + noise_level * 256

    localparam logic [ROW_W-1:0] ROW_LIMIT = 11'd2047;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] REG_NOISE_LEVEL = 2'd1;
    localparam logic [1:0] REG_LINE_WIDTH  = 2'd2;

    localparam logic [WS_W-1:0]  RST_WINDOW_SIZE = 4'd15;
    localparam logic [NL_W-1:0]  RST_NOISE_LEVEL = 16'd225;
    localparam logic [PLW_W-1:0] RST_LINE_WIDTH  = 11'd1024;

    typedef enum logic [1:0] {
        OP_MEAN,
        OP_SQ,
        OP_VAR,
        OP_K
    } div_op_t;

    typedef struct packed {
        logic       accept;
        logic       rd_ctr;
        logic       update;
        logic       prep;
        logic       div_start;
        logic       div_cap;
        div_op_t    op;
        logic [1:0] ch;
        logic       mix;
        logic       load_out;
    } lvf_cmd_t;

    typedef struct packed {
        logic emit;
        logic div_done;
        logic out_free;
    } lvf_stat_t;

endpackage

FILE: hdl/lvf_ram.sv
// ============================================================================
// lvf_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module lvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/lvf_div.sv
// ============================================================================
// lvf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module lvf_div #(
    parameter int W = 38
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quot
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     q_reg;
    logic [W-1:0]     d_reg;
    logic [W:0]       rem_s;
    logic [W:0]       rem_next;
    logic             ge;

    always_comb
    begin
        rem_s    = {rem_reg, q_reg[W-1]};
        ge       = (rem_s >= {1'b0, d_reg});
        rem_next = ge ? (rem_s - {1'b0, d_reg}) : rem_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            d_reg   <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next[W-1:0];
            q_reg   <= {q_reg[W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: hdl/lvf_ctrl.sv
// ============================================================================
// lvf_ctrl
// Sequencer: reads the line and column stores, updates the running sums,
// then, for a pixel that closes a window, walks the three channels through
// mean, S*S/A, variance and gain divisions before handing the result to the
// output register.
module lvf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output lvf_pkg::lvf_cmd_t cmd,
    input  lvf_pkg::lvf_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OLD,
        S_RD_CTR,
        S_UPDATE,
        S_PREP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MIX,
        S_OUT
    } state_t;

    state_t              state_reg;
    lvf_pkg::div_op_t    op_reg;
    logic [1:0]          ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= lvf_pkg::OP_MEAN;
            ch_reg    <= 2'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_RD_OLD;
                    end
                end
                S_RD_OLD:
                begin
                    state_reg <= S_RD_CTR;
                end
                S_RD_CTR:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    ch_reg    <= 2'd0;
                    state_reg <= stat.emit ? S_PREP : S_IDLE;
                end
                S_PREP:
                begin
                    op_reg    <= lvf_pkg::OP_MEAN;
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (stat.div_done)
                    begin
                        case (op_reg)
                            lvf_pkg::OP_MEAN:
                            begin
                                op_reg    <= lvf_pkg::OP_SQ;
                                state_reg <= S_DIV_GO;
                            end
                            lvf_pkg::OP_SQ:
                            begin
                                op_reg    <= lvf_pkg::OP_VAR;
                                state_reg <= S_DIV_GO;
                            end
                            lvf_pkg::OP_VAR:
                            begin
                                op_reg    <= lvf_pkg::OP_K;
                                state_reg <= S_DIV_GO;
                            end
                            default:
                            begin
                                state_reg <= S_MIX;
                            end
                        endcase
                    end
                end
                S_MIX:
                begin
                    if (ch_reg == 2'd2)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= S_PREP;
                    end
                end
                S_OUT:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.ch        = ch_reg;
        cmd.accept    = (state_reg == S_IDLE) && in_valid;
        cmd.rd_ctr    = (state_reg == S_RD_CTR);
        cmd.update    = (state_reg == S_UPDATE);
        cmd.prep      = (state_reg == S_PREP);
        cmd.div_start = (state_reg == S_DIV_GO);
        cmd.div_cap   = (state_reg == S_DIV_WAIT) && stat.div_done;
        cmd.mix       = (state_reg == S_MIX);
        cmd.load_out  = (state_reg == S_OUT) && stat.out_free;
    end

endmodule

FILE: hdl/lvf_datapath.sv
// ============================================================================
// lvf_datapath
// Geometry and raster counters, line store, column sum store, running
// window sums, shared divider, gain mix and the output register.
// ============================================================================
module lvf_datapath #(
    parameter int MAX_WINDOW     = 15,
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lvf_pkg::lvf_cmd_t              cmd,
    output lvf_pkg::lvf_stat_t             stat,
    input  logic [lvf_pkg::PIX_W-1:0]      channel_blue,
    input  logic [lvf_pkg::PIX_W-1:0]      channel_green,
    input  logic [lvf_pkg::PIX_W-1:0]      channel_red,
    input  logic                           frame_start,
    input  logic [lvf_pkg::WS_W-1:0]       window_size,
    input  logic [lvf_pkg::NL_W-1:0]       noise_level,
    input  logic [lvf_pkg::PLW_W-1:0]      padded_line_width,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lvf_pkg::PIX_W-1:0]      filtered_blue,
    output logic [lvf_pkg::PIX_W-1:0]      filtered_green,
    output logic [lvf_pkg::PIX_W-1:0]      filtered_red,
    output logic                           row_last
);

    localparam int NCH     = lvf_pkg::NCH;
    localparam int PW      = lvf_pkg::PIX_W;
    localparam int ODD_MAX = (MAX_WINDOW - 1) | 1;
    localparam int WIN_W   = $clog2(ODD_MAX + 1);
    localparam int LW_W    = $clog2(MAX_LINE_WIDTH + 1);
    localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
    localparam int SLOT_N  = ODD_MAX - 1;
    localparam int SLOT_W  = $clog2(SLOT_N);
    localparam int HS_W    = $clog2(ODD_MAX);
    localparam int AREA_W  = $clog2(ODD_MAX * ODD_MAX + 1);
    localparam int CS_W    = $clog2(ODD_MAX * 255 + 1);
    localparam int CQ_W    = $clog2(ODD_MAX * 65025 + 1);
    localparam int SUM_W   = $clog2(ODD_MAX * ODD_MAX * 255 + 1);
    localparam int SQ_W    = $clog2(ODD_MAX * ODD_MAX * 65025 + 1);
    localparam int CRAM_W  = NCH * (CS_W + CQ_W);
    localparam int LDEPTH  = SLOT_N * MAX_LINE_WIDTH;
    localparam int LA_W    = $clog2(LDEPTH);
    localparam int DW_A    = (2 * SUM_W > SQ_W + 8) ? 2 * SUM_W : SQ_W + 8;
    localparam int DIV_W   = (DW_A > lvf_pkg::VAR_W + 16) ? DW_A : lvf_pkg::VAR_W + 16;
    localparam int RST_WIN = (15 > ODD_MAX) ? ODD_MAX : 15;
    localparam int RST_L0  = (1024 > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : 1024;
    localparam int RST_LIN = (RST_L0 < RST_WIN) ? RST_WIN : RST_L0;
    localparam int K_W     = lvf_pkg::K_W;
    localparam int VAR_W   = lvf_pkg::VAR_W;

    // geometry and raster position
    logic [WIN_W-1:0]          win_reg;
    logic [LW_W-1:0]           line_reg;
    logic [AREA_W-1:0]         area_reg;
    logic [COL_W-1:0]          col_reg;
    logic [lvf_pkg::ROW_W-1:0] row_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [HS_W-1:0]           hs_reg;

    logic [PW-1:0]             pix_reg [NCH];
    logic [NCH*PW-1:0]         old_reg;
    logic [NCH*PW-1:0]         ctr_reg;
    logic [CRAM_W-1:0]         colrd_reg;
    logic                      last_reg;
    logic [SUM_W-1:0]          wsum_reg [NCH];
    logic [SQ_W-1:0]           wsq_reg [NCH];
    logic [CS_W-1:0]           hist_s_reg [ODD_MAX][NCH];
    logic [CQ_W-1:0]           hist_q_reg [ODD_MAX][NCH];

    logic [DIV_W-1:0]          ss_reg;
    logic [DIV_W-1:0]          sq_reg;
    logic [PW-1:0]             mean_reg;
    logic [VAR_W-1:0]          var_reg;
    logic [K_W-1:0]            k_reg;
    logic [PW-1:0]             res_reg [NCH];

    logic                      out_valid_reg;
    logic [PW-1:0]             fb_reg;
    logic [PW-1:0]             fg_reg;
    logic [PW-1:0]             fr_reg;
    logic                      row_last_reg;

    // geometry latched on frame start
    logic [31:0]               w_tmp;
    logic [31:0]               l_tmp;
    logic [WIN_W-1:0]          w_new;
    logic [LW_W-1:0]           l_new;

    always_comb
    begin
        w_tmp = {28'd0, window_size[lvf_pkg::WS_W-1:1], 1'b1};
        if (w_tmp < 32'd3)
        begin
            w_tmp = 32'd3;
        end
        if (w_tmp > 32'(ODD_MAX))
        begin
            w_tmp = 32'(ODD_MAX);
        end
        l_tmp = 32'(padded_line_width);
        if (l_tmp < w_tmp)
        begin
            l_tmp = w_tmp;
        end
        if (l_tmp > 32'(MAX_LINE_WIDTH))
        begin
            l_tmp = 32'(MAX_LINE_WIDTH);
        end
        w_new = w_tmp[WIN_W-1:0];
        l_new = l_tmp[LW_W-1:0];
    end

    // raster bookkeeping
    logic [WIN_W-1:0] rad;
    logic [WIN_W-1:0] wm1;
    logic [WIN_W:0]   cslot_tmp;
    logic [SLOT_W-1:0] cslot;
    logic [COL_W-1:0] ccol;
    logic             rows_full;
    logic             row0;
    logic             emit;
    logic             last;

    always_comb
    begin
        wm1       = win_reg - WIN_W'(1);
        rad       = win_reg >> 1;
        cslot_tmp = (WIN_W+1)'(slot_reg) + (WIN_W+1)'(wm1 - rad);
        if (cslot_tmp >= (WIN_W+1)'(wm1))
        begin
            cslot_tmp = cslot_tmp - (WIN_W+1)'(wm1);
        end
        cslot     = cslot_tmp[SLOT_W-1:0];
        ccol      = (col_reg >= COL_W'(rad)) ? col_reg - COL_W'(rad) : '0;
        row0      = (row_reg == '0);
        rows_full = (row_reg >= lvf_pkg::ROW_W'(wm1));
        emit      = rows_full && (col_reg >= COL_W'(wm1));
        last      = (LW_W'(col_reg) == line_reg - LW_W'(1));
    end

    // line store
    logic [LA_W-1:0]     la_cur;
    logic [LA_W-1:0]     la_ctr;
    logic [NCH*PW-1:0]   line_rdata;
    logic [CRAM_W-1:0]   col_rdata;
    logic [CRAM_W-1:0]   col_wdata;

    assign la_cur = LA_W'(slot_reg) * LA_W'(MAX_LINE_WIDTH) + LA_W'(col_reg);
    assign la_ctr = LA_W'(cslot) * LA_W'(MAX_LINE_WIDTH) + LA_W'(ccol);

    lvf_ram #(
        .WIDTH (NCH * PW),
        .DEPTH (LDEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (la_cur),
        .wdata ({pix_reg[2], pix_reg[1], pix_reg[0]}),
        .raddr (cmd.rd_ctr ? la_ctr : la_cur),
        .rdata (line_rdata)
    );

    lvf_ram #(
        .WIDTH (CRAM_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (col_reg),
        .wdata (col_wdata),
        .raddr (col_reg),
        .rdata (col_rdata)
    );

    // column and window sum update
    logic [CS_W-1:0]  full_s [NCH];
    logic [CQ_W-1:0]  full_q [NCH];
    logic [SUM_W-1:0] new_ws [NCH];
    logic [SQ_W-1:0]  new_wq [NCH];

    always_comb
    begin
        col_wdata = '0;
        for (int i = 0; i < NCH; i++)
        begin
            logic [CS_W-1:0] cs_old;
            logic [CQ_W-1:0] cq_old;
            logic [PW-1:0]   old_p;
            logic [2*PW-1:0] p_sq;
            logic [2*PW-1:0] o_sq;
            logic [SUM_W-1:0] base_s;
            logic [SQ_W-1:0]  base_q;
            cs_old = row0 ? '0 : colrd_reg[i*CS_W +: CS_W];
            cq_old = row0 ? '0 : colrd_reg[NCH*CS_W + i*CQ_W +: CQ_W];
            old_p  = old_reg[i*PW +: PW];
            p_sq   = pix_reg[i] * pix_reg[i];
            o_sq   = old_p * old_p;
            full_s[i] = cs_old + CS_W'(pix_reg[i]);
            full_q[i] = cq_old + CQ_W'(p_sq);
            col_wdata[i*CS_W +: CS_W] = rows_full ? full_s[i] - CS_W'(old_p) : full_s[i];
            col_wdata[NCH*CS_W + i*CQ_W +: CQ_W] =
                rows_full ? full_q[i] - CQ_W'(o_sq) : full_q[i];
            base_s = (col_reg == '0) ? '0 : wsum_reg[i];
            base_q = (col_reg == '0) ? '0 : wsq_reg[i];
            if (col_reg >= COL_W'(win_reg))
            begin
                base_s = base_s - SUM_W'(hist_s_reg[hs_reg][i]);
                base_q = base_q - SQ_W'(hist_q_reg[hs_reg][i]);
            end
            new_ws[i] = base_s + SUM_W'(full_s[i]);
            new_wq[i] = base_q + SQ_W'(full_q[i]);
        end
    end

    // divider operand selection
    logic [SUM_W-1:0]          s_sel;
    logic [SQ_W-1:0]           q_sel;
    logic [2*SUM_W-1:0]        ss_prod;
    logic [DIV_W-1:0]          q_ext;
    logic [DIV_W-1:0]          diff;
    logic [lvf_pkg::DEN_W-1:0] den_k;
    logic                      den_zero;
    logic [DIV_W-1:0]          div_num;
    logic [DIV_W-1:0]          div_den;
    logic [DIV_W-1:0]          quot;
    logic                      div_done;

    always_comb
    begin
        s_sel    = wsum_reg[cmd.ch];
        q_sel    = wsq_reg[cmd.ch];
        ss_prod  = s_sel * s_sel;
        q_ext    = DIV_W'(q_sel);
        diff     = (q_ext > sq_reg) ? q_ext - sq_reg : '0;
        den_k    = lvf_pkg::DEN_W'(var_reg) + lvf_pkg::DEN_W'({noise_level, 8'd0});
        den_zero = (den_k == '0);
        case (cmd.op)
            lvf_pkg::OP_MEAN:
            begin
                div_num = DIV_W'(s_sel);
                div_den = DIV_W'(area_reg);
            end
            lvf_pkg::OP_SQ:
            begin
                div_num = ss_reg;
                div_den = DIV_W'(area_reg);
            end
            lvf_pkg::OP_VAR:
            begin
                div_num = diff << 8;
                div_den = DIV_W'(area_reg);
            end
            default:
            begin
                div_num = DIV_W'(var_reg) << 16;
                div_den = DIV_W'(den_k);
            end
        endcase
    end

    lvf_div #(
        .W (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    // (1-k)*mean + k*centre
    logic [K_W:0]      one_minus_k;
    logic [PW-1:0]     centre;
    logic [K_W+PW:0]   mean_part;
    logic [K_W+PW-1:0] ctr_part;
    logic [K_W+PW+1:0] mix_sum;
    logic [PW-1:0]     mixed;

    always_comb
    begin
        one_minus_k = (K_W+1)'(1 << K_W) - (K_W+1)'(k_reg);
        centre      = ctr_reg[cmd.ch*PW +: PW];
        mean_part   = one_minus_k * mean_reg;
        ctr_part    = k_reg * centre;
        mix_sum     = (K_W+PW+2)'(mean_part) + (K_W+PW+2)'(ctr_part);
        mixed       = (mix_sum[K_W+PW+1:K_W] > (PW+2)'(255)) ? 8'd255 : mix_sum[K_W+PW-1:K_W];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WIN_W'(RST_WIN);
            line_reg      <= LW_W'(RST_LIN);
            area_reg      <= AREA_W'(RST_WIN * RST_WIN);
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            hs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && frame_start)
            begin
                win_reg  <= w_new;
                line_reg <= l_new;
                area_reg <= AREA_W'(w_new * w_new);
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
                hs_reg   <= '0;
            end
            else if (cmd.update)
            begin
                if (last)
                begin
                    col_reg  <= '0;
                    hs_reg   <= '0;
                    slot_reg <= (WIN_W'(slot_reg) == win_reg - WIN_W'(2)) ?
                                '0 : slot_reg + SLOT_W'(1);
                    if (row_reg < lvf_pkg::ROW_LIMIT)
                    begin
                        row_reg <= row_reg + lvf_pkg::ROW_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                    hs_reg  <= (WIN_W'(hs_reg) == wm1) ? '0 : hs_reg + HS_W'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg[0] <= channel_blue;
            pix_reg[1] <= channel_green;
            pix_reg[2] <= channel_red;
        end
        if (cmd.rd_ctr)
        begin
            old_reg   <= line_rdata;
            colrd_reg <= col_rdata;
        end
        if (cmd.update)
        begin
            ctr_reg  <= line_rdata;
            last_reg <= last;
            for (int i = 0; i < NCH; i++)
            begin
                wsum_reg[i]           <= new_ws[i];
                wsq_reg[i]            <= new_wq[i];
                hist_s_reg[hs_reg][i] <= full_s[i];
                hist_q_reg[hs_reg][i] <= full_q[i];
            end
        end
        if (cmd.prep)
        begin
            ss_reg <= DIV_W'(ss_prod);
        end
        if (cmd.div_cap)
        begin
            case (cmd.op)
                lvf_pkg::OP_MEAN:
                begin
                    mean_reg <= (quot > DIV_W'(255)) ? 8'd255 : quot[PW-1:0];
                end
                lvf_pkg::OP_SQ:
                begin
                    sq_reg <= quot;
                end
                lvf_pkg::OP_VAR:
                begin
                    var_reg <= quot[VAR_W-1:0];
                end
                default:
                begin
                    if (den_zero)
                    begin
                        k_reg <= '0;
                    end
                    else
                    begin
                        k_reg <= (quot > DIV_W'(65535)) ? 16'hFFFF : quot[K_W-1:0];
                    end
                end
            endcase
        end
        if (cmd.mix)
        begin
            res_reg[cmd.ch] <= mixed;
        end
        if (cmd.load_out)
        begin
            fb_reg       <= res_reg[0];
            fg_reg       <= res_reg[1];
            fr_reg       <= res_reg[2];
            row_last_reg <= last_reg;
        end
    end

    assign stat.emit     = emit;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign filtered_blue  = fb_reg;
    assign filtered_green = fg_reg;
    assign filtered_red   = fr_reg;
    assign row_last       = row_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten before it was taken");

    a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        LW_W'(col_reg) < line_reg)
        else $error("column counter beyond latched line width");

    a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        WIN_W'(slot_reg) < wm1)
        else $error("ring slot beyond window rows");

endmodule

FILE: hdl/local_variance_edge_preserving_filter.sv
// ============================================================================
// local_variance_edge_preserving_filter
// Lee-type smoothing over a padded 3-channel raster stream, with an APB
// register port for window size, noise level and padded line width.
// ============================================================================
// Sequence: a pixel that closes no window only updates the stores and the
//   running sums and yields no result beat; one that closes a window also runs
//   its divisions (DIV_W = 38 at the default parameters) and then waits until
//   the output register is free. Throughput: one pixel at a time; the shared
//   bit-serial divider (four divisions per channel) sets the pace.
// Reset: rst_n clears counters, control and registers to their reset values;
//   line and column stores are not cleared, the first row of a frame reads
//   column sums as zero.
module local_variance_edge_preserving_filter #(
    parameter int MAX_WINDOW     = 15,
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lvf_pkg::PIX_W-1:0]     channel_blue,
    input  logic [lvf_pkg::PIX_W-1:0]     channel_green,
    input  logic [lvf_pkg::PIX_W-1:0]     channel_red,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lvf_pkg::PIX_W-1:0]     filtered_blue,
    output logic [lvf_pkg::PIX_W-1:0]     filtered_green,
    output logic [lvf_pkg::PIX_W-1:0]     filtered_red,
    output logic                          row_last
);

    logic [lvf_pkg::WS_W-1:0]  window_size_reg;
    logic [lvf_pkg::NL_W-1:0]  noise_level_reg;
    logic [lvf_pkg::PLW_W-1:0] line_width_reg;
    logic                      wr_en;
    logic [1:0]                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= lvf_pkg::RST_WINDOW_SIZE;
            noise_level_reg <= lvf_pkg::RST_NOISE_LEVEL;
            line_width_reg  <= lvf_pkg::RST_LINE_WIDTH;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lvf_pkg::REG_WINDOW_SIZE: window_size_reg <= pwdata[lvf_pkg::WS_W-1:0];
                lvf_pkg::REG_NOISE_LEVEL: noise_level_reg <= pwdata[lvf_pkg::NL_W-1:0];
                lvf_pkg::REG_LINE_WIDTH:  line_width_reg  <= pwdata[lvf_pkg::PLW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lvf_pkg::REG_WINDOW_SIZE: prdata = 32'(window_size_reg);
            lvf_pkg::REG_NOISE_LEVEL: prdata = 32'(noise_level_reg);
            lvf_pkg::REG_LINE_WIDTH:  prdata = 32'(line_width_reg);
            default:                  prdata = '0;
        endcase
    end

    lvf_pkg::lvf_cmd_t  cmd;
    lvf_pkg::lvf_stat_t stat;

    lvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lvf_datapath #(
        .MAX_WINDOW     (MAX_WINDOW),
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .channel_blue      (channel_blue),
        .channel_green     (channel_green),
        .channel_red       (channel_red),
        .frame_start       (frame_start),
        .window_size       (window_size_reg),
        .noise_level       (noise_level_reg),
        .padded_line_width (line_width_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filtered_blue     (filtered_blue),
        .filtered_green    (filtered_green),
        .filtered_red      (filtered_red),
        .row_last          (row_last)
    );

endmodule
